/* rtl/ial_pkg.sv */
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants of the indexed array list engine: action and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ial_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned ENTRY_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned ACTION_BITS = 4;
  localparam int unsigned STATUS_BITS = 2;

  // request actions
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_CLEAR     = 4'd0,
    ACT_INS_FRONT = 4'd1,
    ACT_INS_BACK  = 4'd2,
    ACT_INS_AT    = 4'd3,
    ACT_REPLACE   = 4'd4,
    ACT_READ      = 4'd5,
    ACT_CONTAINS  = 4'd6,
    ACT_RM_VALUE  = 4'd7,
    ACT_RM_FRONT  = 4'd8,
    ACT_RM_BACK   = 4'd9,
    ACT_RM_AT     = 4'd10
  } action_e;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UP,
    S_UP_LAST,
    S_INS_WR,
    S_RD_WAIT,
    S_RM_CAPT,
    S_DOWN,
    S_DEC,
    S_SEARCH,
    S_FINISH
  } ctrl_state_e;

  // walk pointer sources
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_CNT_M1,
    PTR_EP_P1,
    PTR_HIT_P1,
    PTR_STEP
  } ptr_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;        // capture request fields
    ptr_sel_e ptr_sel;     // walk pointer update
    logic     shift_up;    // walk downwards, moving entries up
    logic     walk_rd;     // read store at walk pointer
    logic     walk_wr;     // write back last walk read one slot over
    logic     rd_ep;       // read store at effective position
    logic     wr_val;      // write request value at effective position
    logic     cnt_clr;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_status;
    status_e  status;
    logic     eout_rd;     // result entry from store read data
    logic     eout_val;    // result entry from request value
    logic     set_found;
    logic     publish;     // move result into output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic ep_gt_cnt;
    logic ep_ge_cnt;
    logic ep_eq_cnt;
    logic full;
    logic empty;
    logic ptr_lt_cnt;
    logic ptr_eq_ep;
    logic match;
    logic pend;
    logic out_busy;
  } flags_t;

endpackage

/* rtl/ial_ctrl.sv */
// ----------------------------------------------------------------------------
// ial_ctrl
// Controller of the list engine: checks each request, sequences the store
// walks for insert, remove and search, and hands the result to the output.
// ----------------------------------------------------------------------------
module ial_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ial_pkg::flags_t flags_i,
  output ial_pkg::cmd_t   cmd_o
);

  ial_pkg::ctrl_state_e state_q, state_d;
  ial_pkg::action_e     act;

  assign act = ial_pkg::action_e'(flags_i.action);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ial_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ial_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.ptr_sel = ial_pkg::PTR_HOLD;
    cmd_o.status  = ial_pkg::STAT_OK;

    case (state_q)
      ial_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ial_pkg::S_CHECK;
        end
      end

      ial_pkg::S_CHECK: begin
        state_d = ial_pkg::S_FINISH;
        case (act)
          ial_pkg::ACT_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
          end
          ial_pkg::ACT_INS_FRONT, ial_pkg::ACT_INS_BACK, ial_pkg::ACT_INS_AT: begin
            if (flags_i.ep_gt_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ial_pkg::STAT_RANGE;
            end else if (flags_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ial_pkg::STAT_FULL;
            end else if (flags_i.ep_eq_cnt) begin
              state_d = ial_pkg::S_INS_WR;
            end else begin
              cmd_o.ptr_sel = ial_pkg::PTR_CNT_M1;
              state_d       = ial_pkg::S_UP;
            end
          end
          ial_pkg::ACT_REPLACE: begin
            if (flags_i.ep_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ial_pkg::STAT_RANGE;
            end else begin
              cmd_o.wr_val = 1'b1;
            end
          end
          ial_pkg::ACT_READ: begin
            if (flags_i.ep_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ial_pkg::STAT_RANGE;
            end else begin
              cmd_o.rd_ep = 1'b1;
              state_d     = ial_pkg::S_RD_WAIT;
            end
          end
          ial_pkg::ACT_CONTAINS, ial_pkg::ACT_RM_VALUE: begin
            cmd_o.ptr_sel = ial_pkg::PTR_ZERO;
            state_d       = ial_pkg::S_SEARCH;
          end
          ial_pkg::ACT_RM_FRONT, ial_pkg::ACT_RM_BACK: begin
            if (flags_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ial_pkg::STAT_EMPTY;
            end else begin
              cmd_o.rd_ep = 1'b1;
              state_d     = ial_pkg::S_RM_CAPT;
            end
          end
          ial_pkg::ACT_RM_AT: begin
            if (flags_i.ep_ge_cnt) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ial_pkg::STAT_RANGE;
            end else begin
              cmd_o.rd_ep = 1'b1;
              state_d     = ial_pkg::S_RM_CAPT;
            end
          end
          default: begin
          end
        endcase
      end

      // move entries up, last slot first, until the insert position is read
      ial_pkg::S_UP: begin
        cmd_o.shift_up = 1'b1;
        cmd_o.walk_rd  = 1'b1;
        cmd_o.walk_wr  = 1'b1;
        if (flags_i.ptr_eq_ep) begin
          state_d = ial_pkg::S_UP_LAST;
        end else begin
          cmd_o.ptr_sel = ial_pkg::PTR_STEP;
        end
      end

      ial_pkg::S_UP_LAST: begin
        cmd_o.shift_up = 1'b1;
        cmd_o.walk_wr  = 1'b1;
        state_d        = ial_pkg::S_INS_WR;
      end

      ial_pkg::S_INS_WR: begin
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = ial_pkg::S_FINISH;
      end

      ial_pkg::S_RD_WAIT: begin
        cmd_o.eout_rd = 1'b1;
        state_d       = ial_pkg::S_FINISH;
      end

      ial_pkg::S_RM_CAPT: begin
        cmd_o.eout_rd = 1'b1;
        cmd_o.ptr_sel = ial_pkg::PTR_EP_P1;
        state_d       = ial_pkg::S_DOWN;
      end

      // move entries down over the removed slot
      ial_pkg::S_DOWN: begin
        cmd_o.walk_wr = 1'b1;
        if (flags_i.ptr_lt_cnt) begin
          cmd_o.walk_rd = 1'b1;
          cmd_o.ptr_sel = ial_pkg::PTR_STEP;
        end else begin
          state_d = ial_pkg::S_DEC;
        end
      end

      ial_pkg::S_DEC: begin
        cmd_o.cnt_dec = 1'b1;
        state_d       = ial_pkg::S_FINISH;
      end

      // scan from the front for the first equal entry
      ial_pkg::S_SEARCH: begin
        if (flags_i.match) begin
          cmd_o.set_found = 1'b1;
          if (act == ial_pkg::ACT_RM_VALUE) begin
            cmd_o.eout_val = 1'b1;
            cmd_o.ptr_sel  = ial_pkg::PTR_HIT_P1;
            state_d        = ial_pkg::S_DOWN;
          end else begin
            state_d = ial_pkg::S_FINISH;
          end
        end else if (flags_i.ptr_lt_cnt) begin
          cmd_o.walk_rd = 1'b1;
          cmd_o.ptr_sel = ial_pkg::PTR_STEP;
        end else if (!flags_i.pend) begin
          state_d = ial_pkg::S_FINISH;
        end
      end

      ial_pkg::S_FINISH: begin
        if (!flags_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = ial_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ial_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/ial_dp.sv */
// ----------------------------------------------------------------------------
// ial_dp
// Datapath of the list engine: entry store with one write and one registered
// read port, entry count, walk pointer, result and output registers.
// ----------------------------------------------------------------------------
module ial_dp #(
  parameter int unsigned CAPACITY   = ial_pkg::CAPACITY_DEF,
  parameter int unsigned ENTRY_BITS = ial_pkg::ENTRY_BITS_DEF,
  localparam int unsigned PW        = $clog2(CAPACITY + 1),
  localparam int unsigned AW        = $clog2(CAPACITY)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ial_pkg::ACTION_BITS-1:0] action_i,
  input  logic [PW-1:0]                   position_i,
  input  logic [ENTRY_BITS-1:0]           entry_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ENTRY_BITS-1:0]           entry_out_o,
  output logic                            found_o,
  output logic [PW-1:0]                   length_o,
  output logic [ial_pkg::STATUS_BITS-1:0] status_o,
  input  ial_pkg::cmd_t                   cmd_i,
  output ial_pkg::flags_t                 flags_o
);

  // entry store
  logic [ENTRY_BITS-1:0] mem [CAPACITY];

  // request operands
  logic [ial_pkg::ACTION_BITS-1:0] op_q;
  logic [PW-1:0]                   pos_q;
  logic [ENTRY_BITS-1:0]           val_q;

  // list state and walk
  logic [PW-1:0]         cnt_q, cnt_d;
  logic [PW-1:0]         ptr_q, ptr_d;
  logic [PW-1:0]         ep;
  logic [AW-1:0]         rd_addr_q;
  logic [ENTRY_BITS-1:0] rd_data_q;
  logic                  pend_q;

  // result under construction
  logic [ENTRY_BITS-1:0]           eout_q;
  logic                            found_q;
  logic [ial_pkg::STATUS_BITS-1:0] stat_q;

  // output register
  logic                            out_valid_q;
  logic [ENTRY_BITS-1:0]           out_entry_q;
  logic                            out_found_q;
  logic [PW-1:0]                   out_len_q;
  logic [ial_pkg::STATUS_BITS-1:0] out_stat_q;

  // store port selection
  logic                  mem_we, mem_re;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [ENTRY_BITS-1:0] wr_data;

  // effective position of the request
  always_comb begin
    case (ial_pkg::action_e'(op_q))
      ial_pkg::ACT_INS_FRONT, ial_pkg::ACT_RM_FRONT: ep = '0;
      ial_pkg::ACT_INS_BACK:                         ep = cnt_q;
      ial_pkg::ACT_RM_BACK:                          ep = cnt_q - PW'(1);
      default:                                       ep = pos_q;
    endcase
  end

  // status towards the controller
  always_comb begin
    flags_o            = '0;
    flags_o.action     = op_q;
    flags_o.ep_gt_cnt  = (ep > cnt_q);
    flags_o.ep_ge_cnt  = (ep >= cnt_q);
    flags_o.ep_eq_cnt  = (ep == cnt_q);
    flags_o.full       = (cnt_q >= PW'(CAPACITY));
    flags_o.empty      = (cnt_q == '0);
    flags_o.ptr_lt_cnt = (ptr_q < cnt_q);
    flags_o.ptr_eq_ep  = (ptr_q == ep);
    flags_o.match      = pend_q && (rd_data_q == val_q);
    flags_o.pend       = pend_q;
    flags_o.out_busy   = out_valid_q && out_stall_i;
  end

  // store port muxing
  always_comb begin
    mem_we  = cmd_i.wr_val || (cmd_i.walk_wr && pend_q);
    wr_addr = ep[AW-1:0];
    wr_data = val_q;
    if (!cmd_i.wr_val) begin
      wr_addr = cmd_i.shift_up ? (rd_addr_q + AW'(1)) : (rd_addr_q - AW'(1));
      wr_data = rd_data_q;
    end
    mem_re  = cmd_i.walk_rd || cmd_i.rd_ep;
    rd_addr = cmd_i.walk_rd ? ptr_q[AW-1:0] : ep[AW-1:0];
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // walk pointer next value
  always_comb begin
    case (cmd_i.ptr_sel)
      ial_pkg::PTR_ZERO:   ptr_d = '0;
      ial_pkg::PTR_CNT_M1: ptr_d = cnt_q - PW'(1);
      ial_pkg::PTR_EP_P1:  ptr_d = ep + PW'(1);
      ial_pkg::PTR_HIT_P1: ptr_d = PW'(rd_addr_q) + PW'(1);
      ial_pkg::PTR_STEP:   ptr_d = cmd_i.shift_up ? (ptr_q - PW'(1)) : (ptr_q + PW'(1));
      default:             ptr_d = ptr_q;
    endcase
  end

  // count next value
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + PW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - PW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pend_q      <= cmd_i.walk_rd;
      out_valid_q <= cmd_i.publish || (out_valid_q && out_stall_i);
    end
  end

  // operand, pointer and result registers
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      op_q    <= action_i;
      pos_q   <= position_i;
      val_q   <= entry_value_i;
      eout_q  <= '0;
      found_q <= 1'b0;
      stat_q  <= ial_pkg::STAT_OK;
    end else begin
      if (cmd_i.eout_rd) begin
        eout_q <= rd_data_q;
      end else if (cmd_i.eout_val) begin
        eout_q <= val_q;
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
      if (cmd_i.set_status) begin
        stat_q <= cmd_i.status;
      end
    end
    if (cmd_i.publish) begin
      out_entry_q <= eout_q;
      out_found_q <= found_q;
      out_len_q   <= cnt_q;
      out_stat_q  <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign entry_out_o = out_entry_q;
  assign found_o     = out_found_q;
  assign length_o    = out_len_q;
  assign status_o    = out_stat_q;

endmodule

/* rtl/indexed_array_list_engine.sv */
// One transaction at a time: a new request is accepted only once the result
// of the last one has loaded into the output register; loading waits while a
// held result is stalled at the output.
// Reset: the count and handshake state clear at once; the store is not cleared.
// ----------------------------------------------------------------------------
// indexed_array_list_engine
// Ordered list of entries in a store of CAPACITY slots: clear, insert, replace,
// read, search and remove with shifting, one result per request.
// ----------------------------------------------------------------------------
module indexed_array_list_engine #(
  parameter int unsigned CAPACITY   = ial_pkg::CAPACITY_DEF,
  parameter int unsigned ENTRY_BITS = ial_pkg::ENTRY_BITS_DEF,
  localparam int unsigned PW        = $clog2(CAPACITY + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ial_pkg::ACTION_BITS-1:0] action_i,
  input  logic [PW-1:0]                   position_i,
  input  logic [ENTRY_BITS-1:0]           entry_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ENTRY_BITS-1:0]           entry_out_o,
  output logic                            found_o,
  output logic [PW-1:0]                   length_o,
  output logic [ial_pkg::STATUS_BITS-1:0] status_o
);

  ial_pkg::cmd_t   cmd;
  ial_pkg::flags_t flags;

  // sequencing
  ial_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // store, count and result registers
  ial_dp #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .position_i    (position_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_out_o   (entry_out_o),
    .found_o       (found_o),
    .length_o      (length_o),
    .status_o      (status_o),
    .cmd_i         (cmd),
    .flags_o       (flags)
  );

endmodule
